// ----- rtl/rchf_pkg.sv -----
// shared types and constants for the roi cluster hit filter
// no dependencies
package rchf_pkg;

	localparam int unsigned MAX_ROIS_DEF  = 64;
	localparam int unsigned CELL_BITS_DEF = 10;
	localparam int unsigned SENSOR_W      = 16;
	localparam int unsigned COORD_W       = 10;
	localparam int unsigned NTH_W         = 16;
	localparam int unsigned CFG_W         = 16;
	localparam int unsigned CFG_IDX_W     = 2;

	typedef enum logic [1:0] {
		KIND_EVENT = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_PIXEL = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_SCHED  = 2'd0,
		MODE_FILTER = 2'd1,
		MODE_BYPASS = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FILTER_MODE    = 2'd0,
		REG_SKIP_NTH       = 2'd1,
		REG_CREATE_OUTSIDE = 2'd2
	} reg_idx_t;

	// control part of one beat travelling down the cell chain
	typedef struct packed {
		logic  valid;
		kind_t kind;
		logic  last;
		logic  bypass;
		logic  overflow;
		logic  hit;
	} beat_ctl_t;

	function automatic int unsigned count_bits(input int unsigned n);
		return $clog2(n + 1);
	endfunction

endpackage

// ----- rtl/rchf_front.sv -----
// front stage: config registers, roi count, event bypass schedule
// depends on rchf_pkg
module rchf_front #(
	parameter int unsigned MAX_ROIS  = rchf_pkg::MAX_ROIS_DEF,
	parameter int unsigned CELL_BITS = rchf_pkg::CELL_BITS_DEF,
	parameter int unsigned CNT_W     = rchf_pkg::count_bits(MAX_ROIS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  item_valid,
	input  logic [1:0]                            kind,
	input  logic [rchf_pkg::SENSOR_W-1:0]         sensor_id,
	input  logic [rchf_pkg::COORD_W-1:0]          roi_min_u,
	input  logic [rchf_pkg::COORD_W-1:0]          roi_max_u,
	input  logic [rchf_pkg::COORD_W-1:0]          roi_min_v,
	input  logic [rchf_pkg::COORD_W-1:0]          roi_max_v,
	input  logic [rchf_pkg::COORD_W-1:0]          pixel_u,
	input  logic [rchf_pkg::COORD_W-1:0]          pixel_v,
	input  logic                                  last_pixel,
	input  logic                                  cfg_we,
	input  logic [rchf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rchf_pkg::CFG_W-1:0]            cfg_data,
	output rchf_pkg::beat_ctl_t                   ctl_s0,
	output logic [rchf_pkg::SENSOR_W-1:0]         sensor_s0,
	output logic [3:0][CELL_BITS-1:0]             box_s0,
	output logic [CNT_W-1:0]                      tag_s0
);
	import rchf_pkg::*;

	logic [CNT_W-1:0] roi_cnt_q;
	logic             ovf_q;
	logic             bypass_q;
	logic [NTH_W-1:0] evt_cnt_q;
	logic [1:0]       mode_q;
	logic [NTH_W-1:0] nth_q;

	logic             accept;
	logic [NTH_W-1:0] evt_cnt_inc;
	logic             sched_bypass;
	logic             roi_room;
	beat_ctl_t        beat_d;
	logic [CNT_W-1:0] tag_d;
	logic [3:0][CELL_BITS-1:0] box_d;

	assign accept       = item_valid && adv;
	assign evt_cnt_inc  = evt_cnt_q + NTH_W'(1);
	// counter stays below nth, so a multiple means reaching nth
	assign sched_bypass = (nth_q != '0) && (evt_cnt_inc == nth_q);
	assign roi_room     = roi_cnt_q < CNT_W'(MAX_ROIS);

	always_comb begin
		beat_d          = '0;
		beat_d.kind     = kind_t'(kind);
		beat_d.last     = last_pixel;
		beat_d.bypass   = bypass_q;
		beat_d.overflow = ovf_q;
		tag_d           = roi_cnt_q;
		box_d           = '0;
		case (kind_t'(kind))
			KIND_EVENT: begin
				beat_d.valid = accept;
			end
			KIND_LOAD: begin
				beat_d.valid = accept && roi_room;
				box_d[0]     = CELL_BITS'(roi_min_u);
				box_d[1]     = CELL_BITS'(roi_max_u);
				box_d[2]     = CELL_BITS'(roi_min_v);
				box_d[3]     = CELL_BITS'(roi_max_v);
			end
			KIND_PIXEL: begin
				beat_d.valid = accept;
				box_d[0]     = CELL_BITS'(pixel_u);
				box_d[1]     = CELL_BITS'(pixel_v);
			end
			default: begin
				beat_d.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roi_cnt_q <= '0;
			ovf_q     <= 1'b0;
			bypass_q  <= 1'b0;
			evt_cnt_q <= '0;
			mode_q    <= MODE_SCHED;
			nth_q     <= '0;
			ctl_s0    <= '0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_FILTER_MODE: mode_q <= cfg_data[1:0];
					REG_SKIP_NTH: begin
						nth_q     <= cfg_data[NTH_W-1:0];
						evt_cnt_q <= '0;
					end
					default: ;
				endcase
			end
			if (adv) begin
				ctl_s0 <= beat_d;
			end
			if (accept) begin
				case (kind_t'(kind))
					KIND_EVENT: begin
						roi_cnt_q <= '0;
						ovf_q     <= 1'b0;
						case (mode_t'(mode_q))
							MODE_BYPASS: bypass_q <= 1'b1;
							MODE_SCHED: begin
								bypass_q  <= sched_bypass;
								evt_cnt_q <= sched_bypass ? '0 : evt_cnt_inc;
							end
							default: bypass_q <= 1'b0;
						endcase
					end
					KIND_LOAD: begin
						if (roi_room) begin
							roi_cnt_q <= roi_cnt_q + CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sensor_s0 <= sensor_id;
			box_s0    <= box_d;
			tag_s0    <= tag_d;
		end
	end

endmodule

// ----- rtl/rchf_cell.sv -----
// one roi comparator cell: holds one table entry, passes the beat on
// depends on rchf_pkg
module rchf_cell #(
	parameter int unsigned CELL_BITS = rchf_pkg::CELL_BITS_DEF,
	parameter int unsigned CNT_W     = rchf_pkg::count_bits(rchf_pkg::MAX_ROIS_DEF),
	parameter int unsigned IDX       = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  rchf_pkg::beat_ctl_t           ctl_in,
	input  logic [rchf_pkg::SENSOR_W-1:0] sensor_in,
	input  logic [3:0][CELL_BITS-1:0]     box_in,
	input  logic [CNT_W-1:0]              tag_in,
	output rchf_pkg::beat_ctl_t           ctl_out,
	output logic [rchf_pkg::SENSOR_W-1:0] sensor_out,
	output logic [3:0][CELL_BITS-1:0]     box_out,
	output logic [CNT_W-1:0]              tag_out
);
	import rchf_pkg::*;

	logic [SENSOR_W-1:0]       ent_sensor_q;
	logic [3:0][CELL_BITS-1:0] ent_box_q;

	logic      take_load;
	logic      ent_live;
	logic      match;
	beat_ctl_t ctl_d;

	assign take_load = adv && ctl_in.valid && (ctl_in.kind == KIND_LOAD) &&
		(tag_in == CNT_W'(IDX));
	// entry counts only if it was loaded since the last event and before this pixel
	assign ent_live  = CNT_W'(IDX) < tag_in;
	assign match     = ent_live && (ent_sensor_q == sensor_in) &&
		(ent_box_q[0] <= box_in[0]) && (box_in[0] <= ent_box_q[1]) &&
		(ent_box_q[2] <= box_in[1]) && (box_in[1] <= ent_box_q[3]);

	always_comb begin
		ctl_d     = ctl_in;
		ctl_d.hit = ctl_in.hit | ((ctl_in.kind == KIND_PIXEL) && match);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (adv) begin
			ctl_out <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sensor_out <= sensor_in;
			box_out    <= box_in;
			tag_out    <= tag_in;
		end
		if (take_load) begin
			ent_sensor_q <= sensor_in;
			ent_box_q    <= box_in;
		end
	end

endmodule

// ----- rtl/roi_cluster_hit_filter_top.sv -----
// path to result_valid: front register, every roi cell, result register
// throughput: one beat per cycle while the cell chain advances;
// the chain holds while a result waits on a stalled output
// reset: control, counters and config registers clear; roi entries hold no
// reset value and no clearing pass runs, items are taken right after reset
// top level: front stage, chain of roi cells, cluster verdict and output register
module roi_cluster_hit_filter_top #(
	parameter int unsigned MAX_ROIS  = rchf_pkg::MAX_ROIS_DEF,
	parameter int unsigned CELL_BITS = rchf_pkg::CELL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     kind,
	input  logic [rchf_pkg::SENSOR_W-1:0]  sensor_id,
	input  logic [rchf_pkg::COORD_W-1:0]   roi_min_u,
	input  logic [rchf_pkg::COORD_W-1:0]   roi_max_u,
	input  logic [rchf_pkg::COORD_W-1:0]   roi_min_v,
	input  logic [rchf_pkg::COORD_W-1:0]   roi_max_v,
	input  logic [rchf_pkg::COORD_W-1:0]   pixel_u,
	input  logic [rchf_pkg::COORD_W-1:0]   pixel_v,
	input  logic                           last_pixel,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           keep_inside,
	output logic                           keep_outside,
	output logic                           roi_overflow,
	input  logic                           cfg_we,
	input  logic [rchf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rchf_pkg::CFG_W-1:0]     cfg_data
);
	import rchf_pkg::*;

	localparam int unsigned CNT_W = count_bits(MAX_ROIS);

	beat_ctl_t                 ctl_c    [MAX_ROIS+1];
	logic [SENSOR_W-1:0]       sensor_c [MAX_ROIS+1];
	logic [3:0][CELL_BITS-1:0] box_c    [MAX_ROIS+1];
	logic [CNT_W-1:0]          tag_c    [MAX_ROIS+1];

	logic      adv;
	beat_ctl_t tail;
	logic      tail_hit;
	logic      tail_res;

	logic hit_q;
	logic res_valid_q;
	logic create_outside_q;
	logic keep_in_q;
	logic keep_out_q;
	logic ovf_q;

	assign adv          = !res_valid_q || !result_stall;
	assign item_stall   = !adv;
	assign result_valid = res_valid_q;
	assign keep_inside  = keep_in_q;
	assign keep_outside = keep_out_q;
	assign roi_overflow = ovf_q;

	rchf_front #(
		.MAX_ROIS (MAX_ROIS),
		.CELL_BITS(CELL_BITS),
		.CNT_W    (CNT_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_valid(item_valid),
		.kind      (kind),
		.sensor_id (sensor_id),
		.roi_min_u (roi_min_u),
		.roi_max_u (roi_max_u),
		.roi_min_v (roi_min_v),
		.roi_max_v (roi_max_v),
		.pixel_u   (pixel_u),
		.pixel_v   (pixel_v),
		.last_pixel(last_pixel),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ctl_s0    (ctl_c[0]),
		.sensor_s0 (sensor_c[0]),
		.box_s0    (box_c[0]),
		.tag_s0    (tag_c[0])
	);

	for (genvar i = 0; i < MAX_ROIS; i++) begin : g_cell
		rchf_cell #(
			.CELL_BITS(CELL_BITS),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.ctl_in    (ctl_c[i]),
			.sensor_in (sensor_c[i]),
			.box_in    (box_c[i]),
			.tag_in    (tag_c[i]),
			.ctl_out   (ctl_c[i+1]),
			.sensor_out(sensor_c[i+1]),
			.box_out   (box_c[i+1]),
			.tag_out   (tag_c[i+1])
		);
	end

	assign tail     = ctl_c[MAX_ROIS];
	assign tail_hit = hit_q | tail.hit;
	assign tail_res = adv && tail.valid && (tail.kind == KIND_PIXEL) && tail.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q            <= 1'b0;
			res_valid_q      <= 1'b0;
			create_outside_q <= 1'b0;
		end else begin
			if (cfg_we && (reg_idx_t'(cfg_index) == REG_CREATE_OUTSIDE)) begin
				create_outside_q <= cfg_data[0];
			end
			if (adv && tail.valid) begin
				case (tail.kind)
					KIND_EVENT: hit_q <= 1'b0;
					KIND_PIXEL: hit_q <= tail.last ? 1'b0 : tail_hit;
					default: ;
				endcase
			end
			if (tail_res) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail_res) begin
			keep_in_q  <= tail.bypass | tail_hit;
			keep_out_q <= create_outside_q & ~tail.bypass & ~tail_hit;
			ovf_q      <= tail.overflow;
		end
	end

`ifndef SYNTH
	a_verdict_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(keep_inside && keep_outside))
		else $error("keep_inside and keep_outside both set");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(tail.valid && (tail.kind == KIND_PIXEL) &&
			tail.last && adv))
		else $error("result beat without a last pixel at the chain end");

	a_outside_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && keep_outside) |-> create_outside_q)
		else $error("outside verdict while disabled");
`endif

endmodule
